FILE: src/fpga_slave_config_sequencer_top_macros.svh
// Assertion macros for the sequencer's RTL files (used by fscs_core).
`ifndef FPGA_SLAVE_CONFIG_SEQUENCER_TOP_MACROS_SVH
`define FPGA_SLAVE_CONFIG_SEQUENCER_TOP_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define FSCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a condition to a consequence in the same cycle.
`define FSCS_ASSERT_IMPL(label, cond, cons, msg) \
  `FSCS_ASSERT(label, (cond) |-> (cons), msg)

`endif

FILE: src/fscs_pkg.sv
// Shared types and codes of the slave FPGA configuration sequencer.
package fscs_pkg;

  localparam int unsigned TimerW = 17;
  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_LOAD  = 3'd2;
  localparam logic [2:0] OP_AWAIT = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WAIT_LOW  = 3'd1;
  localparam logic [2:0] PH_WAIT_HIGH = 3'd2;
  localparam logic [2:0] PH_READY     = 3'd3;
  localparam logic [2:0] PH_WAIT_DONE = 3'd4;
  localparam logic [2:0] PH_ERROR     = 3'd5;

  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_READY      = 2'd1;
  localparam logic [1:0] ST_CONFIGURED = 2'd2;
  localparam logic [1:0] ST_TIMEOUT    = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] config_byte;
    logic       byte_last;
    logic       init_pin;
    logic       done_pin;
  } item_t;

  typedef struct packed {
    logic       program_level;
    logic       select_level;
    logic       rdwr_level;
    logic       data_valid;
    logic [7:0] data_out;
    logic       data_last;
    logic [1:0] status;
    logic [2:0] phase;
  } result_t;

endpackage

FILE: src/fscs_in_reg.sv
// Input register stage: holds one accepted beat until the step logic takes it.
module fscs_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fscs_pkg::item_t item_i,
  input  logic            down_ready_i,
  output logic            step_o,
  output fscs_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  fscs_pkg::item_t item_q;
  logic            take;

  assign step_o  = valid_q && down_ready_i;
  assign ready_o = !valid_q || down_ready_i;
  assign take    = valid_i && ready_o;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: src/fscs_core.sv
// Sequencer state and the combinational step that turns one item into one result.
`include "fpga_slave_config_sequencer_top_macros.svh"

module fscs_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  fscs_pkg::item_t                 item_i,
  input  logic [fscs_pkg::TimeoutW-1:0]   timeout_i,
  output fscs_pkg::result_t               res_o
);

  localparam logic [fscs_pkg::TimerW-1:0] TimerMax = '1;
  localparam logic [fscs_pkg::TimerW-1:0] TimerOne = {{(fscs_pkg::TimerW-1){1'b0}}, 1'b1};

  logic [2:0]                  phase_q, phase_d;
  logic [fscs_pkg::TimerW-1:0] timer_q, timer_d, timer_inc;
  logic                        prog_q, prog_d;
  logic                        sel_q, sel_d;
  logic                        rdwr_q, rdwr_d;
  logic                        expired;
  logic [1:0]                  status;
  logic                        dvalid;

  // One more unsatisfied tick, saturating.
  assign timer_inc = (timer_q != TimerMax) ? timer_q + TimerOne : timer_q;
  assign expired   = timer_inc > {1'b0, timeout_i};

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    prog_d  = prog_q;
    sel_d   = sel_q;
    rdwr_d  = rdwr_q;
    status  = fscs_pkg::ST_NONE;
    dvalid  = 1'b0;
    unique case (item_i.op)
      fscs_pkg::OP_TICK: begin
        if (phase_q == fscs_pkg::PH_WAIT_LOW) begin
          if (!item_i.init_pin) begin
            prog_d  = 1'b1;
            phase_d = fscs_pkg::PH_WAIT_HIGH;
            timer_d = '0;
          end else begin
            timer_d = timer_inc;
            if (expired) begin
              sel_d   = 1'b1;
              rdwr_d  = 1'b1;
              phase_d = fscs_pkg::PH_ERROR;
              status  = fscs_pkg::ST_TIMEOUT;
            end
          end
        end else if (phase_q == fscs_pkg::PH_WAIT_HIGH) begin
          if (item_i.init_pin) begin
            sel_d   = 1'b0;
            rdwr_d  = 1'b0;
            phase_d = fscs_pkg::PH_READY;
            status  = fscs_pkg::ST_READY;
          end else begin
            timer_d = timer_inc;
            if (expired) begin
              sel_d   = 1'b1;
              rdwr_d  = 1'b1;
              phase_d = fscs_pkg::PH_ERROR;
              status  = fscs_pkg::ST_TIMEOUT;
            end
          end
        end else if (phase_q == fscs_pkg::PH_WAIT_DONE) begin
          if (item_i.done_pin) begin
            phase_d = fscs_pkg::PH_IDLE;
            status  = fscs_pkg::ST_CONFIGURED;
          end else begin
            timer_d = timer_inc;
            if (expired) begin
              phase_d = fscs_pkg::PH_READY;
              status  = fscs_pkg::ST_TIMEOUT;
            end
          end
        end
      end
      fscs_pkg::OP_START: begin
        prog_d  = 1'b0;
        sel_d   = 1'b1;
        rdwr_d  = 1'b1;
        phase_d = fscs_pkg::PH_WAIT_LOW;
        timer_d = '0;
      end
      fscs_pkg::OP_LOAD: begin
        dvalid = (phase_q == fscs_pkg::PH_READY);
      end
      fscs_pkg::OP_AWAIT: begin
        if (phase_q == fscs_pkg::PH_READY) begin
          phase_d = fscs_pkg::PH_WAIT_DONE;
          timer_d = '0;
        end
      end
      fscs_pkg::OP_STOP: begin
        sel_d   = 1'b1;
        rdwr_d  = 1'b1;
        phase_d = fscs_pkg::PH_IDLE;
        timer_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.program_level = prog_d;
    res_o.select_level  = sel_d;
    res_o.rdwr_level    = rdwr_d;
    res_o.data_valid    = dvalid;
    res_o.data_out      = dvalid ? item_i.config_byte : 8'd0;
    res_o.data_last     = dvalid & item_i.byte_last;
    res_o.status        = status;
    res_o.phase         = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fscs_pkg::PH_IDLE;
      timer_q <= '0;
      prog_q  <= 1'b1;
      sel_q   <= 1'b1;
      rdwr_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      prog_q  <= prog_d;
      sel_q   <= sel_d;
      rdwr_q  <= rdwr_d;
    end
  end

  `FSCS_ASSERT_IMPL(a_ready_port_driven,
    (phase_q == fscs_pkg::PH_READY) || (phase_q == fscs_pkg::PH_WAIT_DONE),
    !sel_q && !rdwr_q, "port not selected while ready")
  `FSCS_ASSERT_IMPL(a_wait_low_program, phase_q == fscs_pkg::PH_WAIT_LOW, !prog_q,
    "PROGRAM released while waiting for INIT low")
  `FSCS_ASSERT_IMPL(a_wait_high_program, phase_q == fscs_pkg::PH_WAIT_HIGH,
    prog_q && sel_q && rdwr_q, "bad pin drives while waiting for INIT high")
  `FSCS_ASSERT_IMPL(a_error_released, phase_q == fscs_pkg::PH_ERROR, sel_q && rdwr_q,
    "port still selected after abort")
  `FSCS_ASSERT(a_timer_bound, timer_q <= {1'b1, {(fscs_pkg::TimerW-1){1'b0}}},
    "wait timer ran past its bound")

endmodule

FILE: src/fscs_out_reg.sv
// Result register: holds one result beat until the downstream side takes it.
module fscs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fscs_pkg::result_t res_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output fscs_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  fscs_pkg::result_t res_q;

  assign room_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: src/fpga_slave_config_sequencer_top.sv
// Slave FPGA configuration sequencer: PROGRAM/INIT handshake, byte pass-through, DONE wait.
// Each input beat (tick, start, load byte, await done, stop) yields exactly one result beat
// carrying the PROGRAM, CS and RDWR drive levels, an optional bitstream byte, a status code
// and the phase. One beat is taken per clock while the result register has room; a beat is
// held in the input register, stepped through the combinational state update into the result
// register, and presented on the master side from there. Waits count tick beats against the
// timeout register (reset 1000), which is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module fpga_slave_config_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // config_byte [7:0], init_pin [8], done_pin [9], zero [15:10]
  input  logic [15:0] s_axis_tdata,
  // op [2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // program_level [0], select_level [1], rdwr_level [2], data_out [10:3],
  // status [12:11], phase [15:13]
  output logic [15:0] m_axis_tdata,
  // data_valid [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [fscs_pkg::TimeoutW-1:0] timeout_q;
  fscs_pkg::item_t               in_item, reg_item;
  fscs_pkg::result_t             step_res, out_res;
  logic                          step;
  logic                          room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= fscs_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_item.op          = s_axis_tuser;
    in_item.config_byte = s_axis_tdata[7:0];
    in_item.byte_last   = s_axis_tlast;
    in_item.init_pin    = s_axis_tdata[8];
    in_item.done_pin    = s_axis_tdata[9];
  end

  fscs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .item_i       (in_item),
    .down_ready_i (room),
    .step_o       (step),
    .item_o       (reg_item)
  );

  fscs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (reg_item),
    .timeout_i (timeout_q),
    .res_o     (step_res)
  );

  fscs_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (step_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.phase, out_res.status, out_res.data_out,
                         out_res.rdwr_level, out_res.select_level, out_res.program_level};
  assign m_axis_tuser = out_res.data_valid;
  assign m_axis_tlast = out_res.data_last;

endmodule

FILE: sim/fpga_slave_config_sequencer_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the slave FPGA configuration sequencer, directed and random beats.
module fpga_slave_config_sequencer_top_test;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // config_byte [7:0], init_pin [8], done_pin [9], zero [15:10]
  logic [15:0] s_axis_tdata;
  // op [2:0]
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // program_level [0], select_level [1], rdwr_level [2], data_out [10:3],
  // status [12:11], phase [15:13]
  logic [15:0] m_axis_tdata;
  // data_valid [0]
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Predicted sequencer state and timeout register.
  logic [2:0]                    seq_phase;
  logic [fscs_pkg::TimerW-1:0]   wait_ticks;
  logic                          prog_drive;
  logic                          cs_drive;
  logic                          rw_drive;
  logic [fscs_pkg::TimeoutW-1:0] timeout_limit;

  fscs_pkg::result_t pin_results_q[$];
  fscs_pkg::result_t want_res;
  int unsigned       fail_count = 0;
  int unsigned       beats_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       gap_max = 0;
  int unsigned       cycle_count = 0;
  int unsigned       stall_mode = 0;

  always #2 clk_i = ~clk_i;

  fpga_slave_config_sequencer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The wait counter saturates; the wait fails once it passes the timeout register.
  function automatic logic count_unmet_tick();
    if (wait_ticks != '1) wait_ticks++;
    return wait_ticks > {1'b0, timeout_limit};
  endfunction

  function automatic fscs_pkg::result_t advance_sequencer(fscs_pkg::item_t beat);
    fscs_pkg::result_t res;
    res = '0;
    res.status = fscs_pkg::ST_NONE;
    case (beat.op)
      fscs_pkg::OP_TICK: begin
        if (seq_phase == fscs_pkg::PH_WAIT_LOW) begin
          if (!beat.init_pin) begin
            prog_drive = 1'b1;
            seq_phase = fscs_pkg::PH_WAIT_HIGH;
            wait_ticks = '0;
          end else if (count_unmet_tick()) begin
            cs_drive = 1'b1;
            rw_drive = 1'b1;
            seq_phase = fscs_pkg::PH_ERROR;
            res.status = fscs_pkg::ST_TIMEOUT;
          end
        end else if (seq_phase == fscs_pkg::PH_WAIT_HIGH) begin
          if (beat.init_pin) begin
            cs_drive = 1'b0;
            rw_drive = 1'b0;
            seq_phase = fscs_pkg::PH_READY;
            res.status = fscs_pkg::ST_READY;
          end else if (count_unmet_tick()) begin
            cs_drive = 1'b1;
            rw_drive = 1'b1;
            seq_phase = fscs_pkg::PH_ERROR;
            res.status = fscs_pkg::ST_TIMEOUT;
          end
        end else if (seq_phase == fscs_pkg::PH_WAIT_DONE) begin
          if (beat.done_pin) begin
            seq_phase = fscs_pkg::PH_IDLE;
            res.status = fscs_pkg::ST_CONFIGURED;
          end else if (count_unmet_tick()) begin
            // A DONE timeout is reported but the port stays ready.
            seq_phase = fscs_pkg::PH_READY;
            res.status = fscs_pkg::ST_TIMEOUT;
          end
        end
      end
      fscs_pkg::OP_START: begin
        prog_drive = 1'b0;
        cs_drive = 1'b1;
        rw_drive = 1'b1;
        seq_phase = fscs_pkg::PH_WAIT_LOW;
        wait_ticks = '0;
      end
      fscs_pkg::OP_LOAD: begin
        if (seq_phase == fscs_pkg::PH_READY) begin
          res.data_valid = 1'b1;
          res.data_out = beat.config_byte;
          res.data_last = beat.byte_last;
        end
      end
      fscs_pkg::OP_AWAIT: begin
        if (seq_phase == fscs_pkg::PH_READY) begin
          seq_phase = fscs_pkg::PH_WAIT_DONE;
          wait_ticks = '0;
        end
      end
      fscs_pkg::OP_STOP: begin
        cs_drive = 1'b1;
        rw_drive = 1'b1;
        seq_phase = fscs_pkg::PH_IDLE;
        wait_ticks = '0;
      end
      default: ;
    endcase
    res.program_level = prog_drive;
    res.select_level = cs_drive;
    res.rdwr_level = rw_drive;
    res.phase = seq_phase;
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps when gap_max is nonzero.
  task automatic send_beat(input logic [2:0] op, input logic [7:0] cbyte, input logic last,
                           input logic init, input logic done);
    fscs_pkg::item_t beat;
    int unsigned     gap;
    beat.op = op;
    beat.config_byte = cbyte;
    beat.byte_last = last;
    beat.init_pin = init;
    beat.done_pin = done;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= beat.op;
    s_axis_tdata <= {6'b0, beat.done_pin, beat.init_pin, beat.config_byte};
    s_axis_tlast <= beat.byte_last;
    do @(posedge clk_i); while (!s_axis_tready);
    pin_results_q.push_back(advance_sequencer(beat));
    beats_sent++;
  endtask

  task automatic send_tick(input logic init, input logic done);
    send_beat(fscs_pkg::OP_TICK, 8'($urandom), 1'($urandom), init, done);
  endtask

  task automatic send_op(input logic [2:0] op);
    send_beat(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_limit = value;
  endtask

  task automatic test_inert_ops();
    logic [2:0] op_code;
    send_tick(1'b0, 1'b1);
    send_beat(fscs_pkg::OP_LOAD, 8'hA5, 1'b1, 1'b1, 1'b0);
    send_op(fscs_pkg::OP_AWAIT);
    // Codes above stop are treated like an idle tick.
    op_code = fscs_pkg::OP_STOP;
    repeat (3) begin
      op_code++;
      send_op(op_code);
    end
  endtask

  task automatic test_bring_up_and_load();
    send_op(fscs_pkg::OP_START);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_beat(fscs_pkg::OP_LOAD, 8'h00, 1'b0, 1'b0, 1'b0);
    send_beat(fscs_pkg::OP_LOAD, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_op(fscs_pkg::OP_AWAIT);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_timeouts();
    write_timeout(16'h0000);
    send_op(fscs_pkg::OP_START);
    send_tick(1'b1, 1'b0);
    send_op(fscs_pkg::OP_START);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_op(fscs_pkg::OP_STOP);
    send_op(fscs_pkg::OP_START);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_op(fscs_pkg::OP_AWAIT);
    send_tick(1'b1, 1'b0);
    send_op(fscs_pkg::OP_AWAIT);
    send_tick(1'b0, 1'b1);
  endtask

  // One bring-up with random wait lengths, occasionally cut short by stop or start.
  task automatic run_bring_up();
    int unsigned n;
    int unsigned cap;
    int unsigned k;
    cap = (timeout_limit < 12) ? timeout_limit + 2 : 8;
    send_op(fscs_pkg::OP_START);
    if ($urandom_range(0, 15) == 0) begin
      send_op($urandom_range(0, 1) ? fscs_pkg::OP_STOP : fscs_pkg::OP_START);
      return;
    end
    n = $urandom_range(0, cap);
    for (k = 0; k < n && seq_phase == fscs_pkg::PH_WAIT_LOW; k++) begin
      if ($urandom_range(0, 9) == 0) send_op(fscs_pkg::OP_LOAD);
      else send_tick(1'b1, 1'($urandom));
    end
    if (seq_phase == fscs_pkg::PH_WAIT_LOW) send_tick(1'b0, 1'($urandom));
    n = $urandom_range(0, cap);
    for (k = 0; k < n && seq_phase == fscs_pkg::PH_WAIT_HIGH; k++) begin
      if ($urandom_range(0, 9) == 0) send_op(fscs_pkg::OP_AWAIT);
      else send_tick(1'b0, 1'($urandom));
    end
    if (seq_phase == fscs_pkg::PH_WAIT_HIGH) send_tick(1'b1, 1'($urandom));
    if (seq_phase == fscs_pkg::PH_READY) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) begin
        send_beat(fscs_pkg::OP_LOAD, 8'($urandom), k == n - 1, 1'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 11) == 0) begin
        send_op(fscs_pkg::OP_STOP);
        return;
      end
      send_op(fscs_pkg::OP_AWAIT);
      n = $urandom_range(0, cap);
      for (k = 0; k < n && seq_phase == fscs_pkg::PH_WAIT_DONE; k++) begin
        send_tick(1'($urandom), 1'b0);
      end
      if (seq_phase == fscs_pkg::PH_WAIT_DONE) begin
        if ($urandom_range(0, 7) == 0) send_op(fscs_pkg::OP_STOP);
        else send_tick(1'($urandom), 1'b1);
      end else if (seq_phase == fscs_pkg::PH_READY && $urandom_range(0, 1) == 1) begin
        send_op(fscs_pkg::OP_AWAIT);
        send_tick(1'($urandom), 1'b1);
      end
    end
    if (seq_phase == fscs_pkg::PH_ERROR && $urandom_range(0, 1) == 1) begin
      send_op(fscs_pkg::OP_STOP);
    end
  endtask

  task automatic run_random_phase(input logic [15:0] timeout, input int unsigned count,
                                  input int unsigned gap);
    int unsigned end_at;
    int unsigned k;
    write_timeout(timeout);
    gap_max = gap;
    end_at = beats_sent + count;
    while (beats_sent < end_at) begin
      if ($urandom_range(0, 6) == 0) begin
        for (k = $urandom_range(1, 4); k > 0; k--) send_op(3'($urandom_range(0, 7)));
      end else begin
        run_bring_up();
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(16'h0001, 150, 0);
    run_random_phase(16'h0004, 150, 3);
    run_random_phase(16'hFFFF, 120, 8);
    run_random_phase(16'h0009, 150, 2);
    run_random_phase(16'($urandom_range(2, 30)), 180, 5);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pin_results_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_res = pin_results_q.pop_front();
        check_field("program_level", 8'(want_res.program_level), 8'(m_axis_tdata[0]));
        check_field("select_level", 8'(want_res.select_level), 8'(m_axis_tdata[1]));
        check_field("rdwr_level", 8'(want_res.rdwr_level), 8'(m_axis_tdata[2]));
        check_field("data_out", want_res.data_out, m_axis_tdata[10:3]);
        check_field("status", 8'(want_res.status), 8'(m_axis_tdata[12:11]));
        check_field("phase", 8'(want_res.phase), 8'(m_axis_tdata[15:13]));
        check_field("data_valid", 8'(want_res.data_valid), 8'(m_axis_tuser));
        check_field("data_last", 8'(want_res.data_last), 8'(m_axis_tlast));
      end
    end
    if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (cycle_count % 5 != 0);
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= fscs_pkg::OP_TICK;
    s_axis_tlast <= 1'b0;
    seq_phase = fscs_pkg::PH_IDLE;
    wait_ticks = '0;
    prog_drive = 1'b1;
    cs_drive = 1'b1;
    rw_drive = 1'b1;
    timeout_limit = fscs_pkg::TimeoutReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_max = 4;
    test_inert_ops();
    test_bring_up_and_load();
    test_timeouts();
    test_random();
    wait_quiet();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/fscs_pkg.sv
src/fscs_in_reg.sv
src/fscs_core.sv
src/fscs_out_reg.sv
src/fpga_slave_config_sequencer_top.sv
sim/fpga_slave_config_sequencer_top_test.sv
